/* design/u8u16_pkg.sv */
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder package
// Shared payload types, job codes and constants for the transcoder blocks.
// ----------------------------------------------------------------------------
package u8u16_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_string;
	} in_item_t;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        error;
		logic        last;
	} out_item_t;

	localparam logic [1:0] JOB_UNIT  = 2'd0;
	localparam logic [1:0] JOB_PAIR  = 2'd1;
	localparam logic [1:0] JOB_ERROR = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [19:0] value;
		logic        last;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int CP_W = 31;

	localparam logic [CP_W-1:0] BMP_MAX    = 31'h0000FFFF;
	localparam logic [CP_W-1:0] PAIR_MAX   = 31'h000EFFFF;
	localparam logic [15:0]     HIGH_BASE  = 16'hD800;
	localparam logic [15:0]     LOW_BASE   = 16'hDC00;
	localparam logic [15:0]     HIGH_ADJ   = 16'h0040;
	localparam logic [7:0]      LEAD_MAX   = 8'hFD;
	localparam logic [7:0]      CONT_MAX   = 8'hBF;

endpackage

/* design/u8u16_front.sv */
// ----------------------------------------------------------------------------
// UTF-8 decoder front end
// Accepts bytes, tracks the partial code point and turns each finished
// character or string error into a job for the output queue.
// ----------------------------------------------------------------------------
module u8u16_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  u8u16_pkg::in_item_t     in_data,
	input  u8u16_pkg::queue_status_t q_status,
	output logic                    push,
	output u8u16_pkg::job_t         push_job
);

	logic [u8u16_pkg::CP_W-1:0] partial_q;
	logic [2:0]                 expected_q;
	logic                       error_seen_q;

	logic [u8u16_pkg::CP_W-1:0] partial_n;
	logic [2:0]                 expected_n;
	logic                       error_seen_n;
	logic [u8u16_pkg::CP_W-1:0] cp;
	logic                       done;
	logic                       job_valid;
	logic [7:0]                 b;
	logic                       fire;

	assign b        = in_data.in_byte;
	assign in_ready = !q_status.full;
	assign fire     = in_valid && in_ready;
	assign push     = fire && job_valid;

	always_comb begin
		partial_n    = partial_q;
		expected_n   = expected_q;
		error_seen_n = error_seen_q;
		cp           = '0;
		done         = 1'b0;
		job_valid    = 1'b0;
		push_job     = '{kind: u8u16_pkg::JOB_UNIT, value: 20'd0, last: 1'b0};
		if (!error_seen_q) begin
			if (expected_q == 3'd0) begin
				if (!b[7]) begin
					cp   = {23'd0, b};
					done = 1'b1;
				end else if (!b[6] || b > u8u16_pkg::LEAD_MAX) begin
					error_seen_n = 1'b1;
				end else if (!b[5]) begin
					partial_n  = {26'd0, b[4:0]};
					expected_n = 3'd1;
				end else if (!b[4]) begin
					partial_n  = {27'd0, b[3:0]};
					expected_n = 3'd2;
				end else if (!b[3]) begin
					partial_n  = {28'd0, b[2:0]};
					expected_n = 3'd3;
				end else if (!b[2]) begin
					partial_n  = {29'd0, b[1:0]};
					expected_n = 3'd4;
				end else begin
					partial_n  = {30'd0, b[0]};
					expected_n = 3'd5;
				end
			end else begin
				if (!b[7] || b > u8u16_pkg::CONT_MAX) begin
					error_seen_n = 1'b1;
				end else begin
					partial_n  = {partial_q[u8u16_pkg::CP_W-7:0], b[5:0]};
					expected_n = expected_q - 3'd1;
					if (expected_n == 3'd0) begin
						cp        = partial_n;
						partial_n = '0;
						done      = 1'b1;
					end
				end
			end
			if (done) begin
				if (cp <= u8u16_pkg::BMP_MAX) begin
					job_valid     = 1'b1;
					push_job.kind  = u8u16_pkg::JOB_UNIT;
					push_job.value = cp[19:0];
					push_job.last  = in_data.end_of_string;
				end else if (cp <= u8u16_pkg::PAIR_MAX) begin
					job_valid     = 1'b1;
					push_job.kind  = u8u16_pkg::JOB_PAIR;
					push_job.value = cp[19:0];
					push_job.last  = in_data.end_of_string;
				end else begin
					error_seen_n = 1'b1;
				end
			end
		end
		if (in_data.end_of_string) begin
			if (error_seen_n || expected_n != 3'd0) begin
				job_valid     = 1'b1;
				push_job.kind  = u8u16_pkg::JOB_ERROR;
				push_job.value = 20'd0;
				push_job.last  = 1'b1;
			end
			partial_n    = '0;
			expected_n   = 3'd0;
			error_seen_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q    <= '0;
			expected_q   <= 3'd0;
			error_seen_q <= 1'b0;
		end else if (fire) begin
			partial_q    <= partial_n;
			expected_q   <= expected_n;
			error_seen_q <= error_seen_n;
		end
	end

endmodule

/* design/u8u16_queue.sv */
// ----------------------------------------------------------------------------
// Job queue
// Small first-in first-out buffer that decouples the decoder from the
// output sequencer.
// ----------------------------------------------------------------------------
module u8u16_queue (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  u8u16_pkg::job_t          push_job,
	input  logic                     pop,
	output u8u16_pkg::job_t          head,
	output u8u16_pkg::queue_status_t status
);

	u8u16_pkg::job_t                  mem_q [u8u16_pkg::QUEUE_DEPTH];
	logic [u8u16_pkg::QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [u8u16_pkg::QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [u8u16_pkg::QUEUE_CNT_W-1:0] count_q;

	assign head         = mem_q[rd_ptr_q];
	assign status.full  = (count_q == u8u16_pkg::QUEUE_CNT_W'(u8u16_pkg::QUEUE_DEPTH));
	assign status.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* design/u8u16_back.sv */
// ----------------------------------------------------------------------------
// Output sequencer
// Takes jobs from the queue and issues UTF-16 code units, splitting
// surrogate pairs over two output requests.
// ----------------------------------------------------------------------------
module u8u16_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  u8u16_pkg::job_t          head,
	input  u8u16_pkg::queue_status_t q_status,
	output logic                     pop,
	output logic                     out_valid,
	input  logic                     out_ready,
	output u8u16_pkg::out_item_t     out_data
);

	logic                 out_valid_q;
	u8u16_pkg::out_item_t out_q;
	logic                 low_pend_q;
	logic [15:0]          low_unit_q;
	logic                 low_last_q;
	logic                 load;
	logic [15:0]          high_unit;
	logic [15:0]          low_unit;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign load      = !out_valid_q || out_ready;
	assign pop       = load && !low_pend_q && !q_status.empty;

	assign high_unit = u8u16_pkg::HIGH_BASE + {6'd0, head.value[19:10]} - u8u16_pkg::HIGH_ADJ;
	assign low_unit  = u8u16_pkg::LOW_BASE | {6'd0, head.value[9:0]};

	always_ff @(posedge clk) begin
		if (load) begin
			if (low_pend_q) begin
				out_q <= '{code_unit: low_unit_q, error: 1'b0, last: low_last_q};
			end else if (!q_status.empty) begin
				case (head.kind)
					u8u16_pkg::JOB_UNIT: begin
						out_q <= '{code_unit: head.value[15:0], error: 1'b0, last: head.last};
					end
					u8u16_pkg::JOB_PAIR: begin
						out_q      <= '{code_unit: high_unit, error: 1'b0, last: 1'b0};
						low_unit_q <= low_unit;
						low_last_q <= head.last;
					end
					default: begin
						out_q <= '{code_unit: 16'd0, error: 1'b1, last: 1'b1};
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			low_pend_q  <= 1'b0;
		end else if (load) begin
			if (low_pend_q) begin
				out_valid_q <= 1'b1;
				low_pend_q  <= 1'b0;
			end else if (!q_status.empty) begin
				out_valid_q <= 1'b1;
				low_pend_q  <= (head.kind == u8u16_pkg::JOB_PAIR);
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* design/utf8_to_utf16_transcoder.sv */
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder
// Converts a byte stream of UTF-8 strings into UTF-16 code units.
// ----------------------------------------------------------------------------
// The block takes one UTF-8 byte per cycle, with end_of_string on the last
// byte of each string. A character up to 0xFFFF gives one code unit, one up
// to 0xEFFFF gives a surrogate pair of two code units, and any invalid or
// unconvertible input gives a single error result on the last byte of the
// string. The decoder and the output sequencer meet at a four-entry job
// queue, so input runs at one byte per cycle until the output side, limited
// to one code unit per cycle, fills that queue.
module utf8_to_utf16_transcoder (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  u8u16_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output u8u16_pkg::out_item_t out_data
);

	logic                     push;
	logic                     pop;
	u8u16_pkg::job_t          push_job;
	u8u16_pkg::job_t          head;
	u8u16_pkg::queue_status_t q_status;

	u8u16_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_status (q_status),
		.push     (push),
		.push_job (push_job)
	);

	u8u16_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.status   (q_status)
	);

	u8u16_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_status  (q_status),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

/* tb/tb_utf8_to_utf16_transcoder.sv */
// ----------------------------------------------------------------------------
// Testbench for the UTF-8 to UTF-16 transcoder
// Feeds UTF-8 strings byte by byte under random idling on both channels,
// predicts every UTF-16 code unit and error result with a software decoder,
// and compares each result that the block delivers with the oldest one due.
// ----------------------------------------------------------------------------
module tb_utf8_to_utf16_transcoder;

	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 20;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	u8u16_pkg::in_item_t  in_data = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	u8u16_pkg::out_item_t out_data;

	u8u16_pkg::out_item_t due_units[$];
	logic [30:0]          cp_acc = '0;
	logic [2:0]           cont_left = '0;
	logic                 string_bad = 1'b0;

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	bit hold_request = 1'b0;
	int hold_left = 0;
	int stall_cycles = 0;
	int fail_count = 0;
	int bytes_sent = 0;
	int strings_sent = 0;
	int units_checked = 0;
	int errors_checked = 0;
	int surrogates_checked = 0;

	utf8_to_utf16_transcoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic u8u16_pkg::out_item_t make_unit(logic [15:0] unit, logic err, logic fin);
		u8u16_pkg::out_item_t r;
		r.code_unit = unit;
		r.error = err;
		r.last = fin;
		return r;
	endfunction

	// Advances the decoder by one accepted byte and queues the units it yields.
	task automatic decode_byte(input logic [7:0] b, input logic eos);
		logic [30:0]          cp;
		logic                 done;
		u8u16_pkg::out_item_t produced[$];
		cp = '0;
		done = 1'b0;
		if (!string_bad) begin
			if (cont_left == 3'd0) begin
				if (b < 8'h80) begin
					cp = {23'd0, b};
					done = 1'b1;
				end else if (b < 8'hC0 || b > u8u16_pkg::LEAD_MAX) begin
					string_bad = 1'b1;
				end else if (b < 8'hE0) begin
					cp_acc = {26'd0, b[4:0]};
					cont_left = 3'd1;
				end else if (b < 8'hF0) begin
					cp_acc = {27'd0, b[3:0]};
					cont_left = 3'd2;
				end else if (b < 8'hF8) begin
					cp_acc = {28'd0, b[2:0]};
					cont_left = 3'd3;
				end else if (b < 8'hFC) begin
					cp_acc = {29'd0, b[1:0]};
					cont_left = 3'd4;
				end else begin
					cp_acc = {30'd0, b[0]};
					cont_left = 3'd5;
				end
			end else begin
				if (b < 8'h80 || b > u8u16_pkg::CONT_MAX) begin
					string_bad = 1'b1;
				end else begin
					cp_acc = {cp_acc[24:0], b[5:0]};
					cont_left = cont_left - 3'd1;
					if (cont_left == 3'd0) begin
						cp = cp_acc;
						cp_acc = '0;
						done = 1'b1;
					end
				end
			end
			if (done) begin
				if (cp <= u8u16_pkg::BMP_MAX) begin
					produced.push_back(make_unit(cp[15:0], 1'b0, eos));
				end else if (cp <= u8u16_pkg::PAIR_MAX) begin
					produced.push_back(make_unit(
						u8u16_pkg::HIGH_BASE + {6'd0, cp[19:10]} - u8u16_pkg::HIGH_ADJ,
						1'b0, 1'b0));
					produced.push_back(make_unit(u8u16_pkg::LOW_BASE + {6'd0, cp[9:0]},
						1'b0, eos));
				end else begin
					string_bad = 1'b1;
				end
			end
		end
		if (eos) begin
			if (string_bad || cont_left != 3'd0) begin
				produced.delete();
				produced.push_back(make_unit(16'h0000, 1'b1, 1'b1));
			end
			cp_acc = '0;
			cont_left = '0;
			string_bad = 1'b0;
		end
		foreach (produced[i]) due_units.push_back(produced[i]);
	endtask

	task automatic send_byte(input logic [7:0] b, input logic eos);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(0, 99) < tx_idle_pct) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_data.in_byte <= b;
		in_data.end_of_string <= eos;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		decode_byte(b, eos);
		bytes_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (due_units.size() != 0) @(posedge clk);
	endtask

	task automatic send_string(input logic [7:0] s[$]);
		for (int pos = 0; pos < s.size(); pos++) send_byte(s[pos], pos == s.size() - 1);
		strings_sent++;
	endtask

	// Mostly well-formed strings of mixed sequence lengths with random payload bits;
	// a few are corrupted, cut short or given a stray byte.
	task automatic send_random_string(input int max_chars);
		logic [7:0] s[$];
		logic [7:0] lead;
		int nchars, len, pick;
		nchars = $urandom_range(1, max_chars);
		repeat (nchars) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) len = 1;
			else if (pick < 55) len = 2;
			else if (pick < 75) len = 3;
			else if (pick < 93) len = 4;
			else if (pick < 97) len = 5;
			else len = 6;
			case (len)
				1: lead = 8'($urandom_range(0, 127));
				2: lead = 8'hC0 | 8'($urandom_range(0, 31));
				3: lead = 8'hE0 | 8'($urandom_range(0, 15));
				4: lead = 8'hF0 | 8'($urandom_range(0, ($urandom_range(0, 3) == 0) ? 7 : 3));
				5: lead = 8'hF8 | 8'($urandom_range(0, 3));
				default: lead = 8'hFC | 8'($urandom_range(0, 1));
			endcase
			s.push_back(lead);
			repeat (len - 1) s.push_back(8'h80 | 8'($urandom_range(0, 63)));
		end
		pick = $urandom_range(0, 99);
		if (pick < 6) begin
			s[$urandom_range(0, s.size() - 1)] = 8'($urandom_range(0, 255));
		end else if (pick < 10 && s.size() > 1) begin
			void'(s.pop_back());
		end else if (pick < 14) begin
			s.insert($urandom_range(0, s.size()), 8'($urandom_range(0, 255)));
		end
		send_string(s);
	endtask

	task automatic test_directed_cases();
		send_string({8'h00});
		send_string({8'h7F, 8'hDF, 8'hBF, 8'hEF, 8'hBF, 8'hBF});
		send_string({8'hF3, 8'hAF, 8'hBF, 8'hBF});
		send_string({8'hF4, 8'h80, 8'h80, 8'h80});
		send_string({8'h80, 8'h41});
		send_string({8'hFF});
		send_string({8'hFE});
		send_string({8'hC3, 8'h41});
		send_string({8'hFD, 8'hBF});
		send_string({8'hF8});
		wait_drained();
	endtask

	task automatic test_random_strings(input int tx_pct, input int rx_pct, input int nbytes);
		int start;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		start = bytes_sent;
		while (bytes_sent - start < nbytes) send_random_string(6);
		wait_drained();
	endtask

	task automatic test_output_hold_off();
		int start;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_request = 1'b1;
		start = bytes_sent;
		while (bytes_sent - start < 80) send_random_string(4);
		wait_drained();
	endtask

	task automatic test_input_pause();
		tx_idle_pct = 10;
		rx_idle_pct = 20;
		repeat (6) begin
			repeat (3) send_random_string(3);
			wait_drained();
		end
	endtask

	always @(posedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		u8u16_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			units_checked++;
			if (out_data.error) errors_checked++;
			if (out_data.code_unit[15:11] == 5'b11011) surrogates_checked++;
			if (due_units.size() == 0) begin
				$error("unexpected result: code_unit=%h error=%b last=%b",
					out_data.code_unit, out_data.error, out_data.last);
				fail_count++;
			end else begin
				want = due_units.pop_front();
				if (out_data.code_unit !== want.code_unit) begin
					$error("code_unit: expected %h, actual %h", want.code_unit, out_data.code_unit);
					fail_count++;
				end
				if (out_data.error !== want.error) begin
					$error("error: expected %b, actual %b", want.error, out_data.error);
					fail_count++;
				end
				if (out_data.last !== want.last) begin
					$error("last: expected %b, actual %b", want.last, out_data.last);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
		else stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Timeout: no request moved for %0d cycles.", STALL_LIMIT);
			$display("tb_utf8_to_utf16_transcoder: FAIL");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_random_strings(30, 51, 600);
		test_random_strings(51, 30, 600);
		test_random_strings(0, 0, 550);
		test_output_hold_off();
		test_input_pause();
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Sent %0d bytes in %0d strings under both idling patterns and a long output stall.",
			bytes_sent, strings_sent);
		$display("Checked %0d results: %0d surrogate units and %0d error results.",
			units_checked, surrogates_checked, errors_checked);
		if (fail_count == 0) begin
			$display("tb_utf8_to_utf16_transcoder: PASS");
		end else begin
			$display("tb_utf8_to_utf16_transcoder: FAIL");
		end
		$finish;
	end

endmodule
